### rtl/ufd_pkg.sv
// ============================================================================
// ufd_pkg - shared definitions for the uniform-grid derivative stream
// Register map, mode bits and index limits used by the datapath and checker.
// ============================================================================
`default_nettype none

package ufd_pkg;

    // Grid index width and the largest array the block handles
    localparam int IDX_W      = 12;
    localparam int MAX_POINTS = 4096;

    localparam logic [IDX_W-1:0] MAX_INDEX = IDX_W'(MAX_POINTS - 1);
    localparam logic [IDX_W-1:0] MIN_LAST  = IDX_W'(3);

    // Configuration port geometry
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    typedef enum logic [1:0] {
        REG_MODE       = 2'd0,
        REG_LAST_INDEX = 2'd1,
        REG_SCALE      = 2'd2
    } reg_index_t;

    // Mode register: bit 0 selects one-sided ends, bit 1 the second derivative
    localparam int MODE_W            = 2;
    localparam int MODE_BIT_ONESIDED = 0;
    localparam int MODE_BIT_SECOND   = 1;

    localparam logic [MODE_W-1:0] MODE_RESET  = 2'd0;
    localparam logic [IDX_W-1:0]  LAST_RESET  = IDX_W'(3);
    localparam logic [31:0]       SCALE_RESET = 32'h0001_0000;

    // Saturation bounds of a Q16.16 result
    localparam logic [31:0] POS_LIMIT = 32'h7FFF_FFFF;
    localparam logic [31:0] NEG_LIMIT = 32'h8000_0000;

endpackage

`default_nettype wire

### rtl/uniform_fd_derivative_stream.sv
// ============================================================================
// uniform_fd_derivative_stream - streaming central finite-difference block
// Second-order first or second derivatives of a sampled array on a uniform
// grid, with periodic or one-sided ends, scaled and saturated to Q16.16.
// ============================================================================
// Samples c[0..n] of one array (n = last_index) enter one per transaction in
// ascending index order; a new sample is taken every cycle while in_stall is
// low. Each result carries its grid index: interior point j leaves one sample
// behind (when c[j+1] arrives), a one-sided index 0 leaves as soon as its
// stencil is complete, and the sample c[n] releases n-1, n and, for periodic
// mode, the wrapped index 0, in that order. last_of_run marks the final result
// that a sample causes. Results leave at one per cycle while out_stall is low,
// through a 32x32 scale multiplier and a narrow one for the guard bits; a
// sample that causes two or three results sends them one after another, and a
// four-entry item queue absorbs these bursts, so the input stalls only when
// that queue, counted together with the sample in the input register, is full.
// A result passes through the input register, the item queue written by the
// stencil, the scale product register and the round/saturate output register,
// in that order. Configuration (mode, last_index, scale) is written through
// the APB port; the user must write it only while the block is idle, as the
// block does not enforce this. No clearing pass is needed after reset.
// ============================================================================
`default_nettype none

module uniform_fd_derivative_stream
    import ufd_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 32
)
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,

    // Sample channel
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic signed [SAMPLE_WIDTH-1:0] sample,

    // Result channel
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic signed [31:0]                  deriv_value,
    output logic [IDX_W-1:0]                    point_index,
    output logic                                last_of_run,
    output logic                                saturated,

    // Configuration port
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [ADDR_W-1:0]              paddr,
    input  wire logic [DATA_W-1:0]              pwdata,
    output logic [DATA_W-1:0]                   prdata,
    output logic                                pready
);

    // Stencil sums need four guard bits: the largest coefficient sum is 12
    localparam int SW      = SAMPLE_WIDTH + 4;
    localparam int HI_W    = (SW > 32) ? SW - 32 : 1;
    localparam int MAG_PAD = 32 + HI_W;
    localparam int HP_W    = HI_W + 32;
    localparam int Q_DEPTH = 4;
    localparam int QP_W    = $clog2(Q_DEPTH);
    localparam int QC_W    = $clog2(Q_DEPTH + 1);
    localparam int RND_W   = 49;

    typedef struct packed {
        logic            neg;
        logic [SW-1:0]   mag;
        logic [IDX_W-1:0] idx;
    } res_t;

    typedef struct packed {
        logic [1:0]      cnt;
        res_t [2:0]      res;
    } qent_t;

    function automatic res_t make_res(logic signed [SW-1:0] s, logic [IDX_W-1:0] i);
        res_t r;
        r.neg = s[SW-1];
        r.mag = s[SW-1] ? SW'(-s) : SW'(s);
        r.idx = i;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------------
    logic [MODE_W-1:0] mode_reg;
    logic [IDX_W-1:0]  last_index_reg;
    logic [31:0]       scale_reg;
    logic              cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_RESET;
            last_index_reg <= LAST_RESET;
            scale_reg      <= SCALE_RESET;
        end
        else if (cfg_write)
        begin
            case (reg_index_t'(paddr[ADDR_W-1:2]))
                REG_MODE:       mode_reg       <= pwdata[MODE_W-1:0];
                REG_LAST_INDEX: last_index_reg <= pwdata[IDX_W-1:0];
                REG_SCALE:      scale_reg      <= pwdata;
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_index_t'(paddr[ADDR_W-1:2]))
            REG_MODE:       prdata = DATA_W'(mode_reg);
            REG_LAST_INDEX: prdata = DATA_W'(last_index_reg);
            REG_SCALE:      prdata = scale_reg;
            default:        prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------------
    // Input register
    // ------------------------------------------------------------------------
    logic                           in_valid_reg;
    logic signed [SAMPLE_WIDTH-1:0] x_reg;
    logic [QC_W-1:0]                q_count_reg;
    logic                           accept_in;

    // Admit a sample only when the queue has room for it and the pending one
    assign in_stall  = (q_count_reg + QC_W'(in_valid_reg)) >= QC_W'(Q_DEPTH);
    assign accept_in = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= accept_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept_in)
        begin
            x_reg <= sample;
        end
    end

    // ------------------------------------------------------------------------
    // Stencil stage: array position, sums and result selection
    // ------------------------------------------------------------------------
    logic [IDX_W-1:0]               count_reg;
    logic signed [SAMPLE_WIDTH-1:0] f0_reg, f1_reg;
    logic signed [SAMPLE_WIDTH-1:0] w0_reg, w1_reg, w2_reg;

    logic [IDX_W-1:0]  n_eff, k;
    logic              second, onesided;
    logic signed [SW-1:0] xe, f0e, f1e, w0e, w1e, w2e;
    logic signed [SW-1:0] s_zero, s_inner, s_end, s_wrap;
    logic              v_zero, v_inner, v_end, v_wrap;
    res_t              r_zero, r_inner, r_end, r_wrap;
    qent_t             q_new;

    always_comb
    begin
        n_eff = (last_index_reg < MIN_LAST) ? MIN_LAST : last_index_reg;
        if (n_eff > MAX_INDEX)
        begin
            n_eff = MAX_INDEX;
        end
        // Restart the array if last_index dropped below the running count
        k = (count_reg > n_eff) ? '0 : count_reg;

        second   = mode_reg[MODE_BIT_SECOND];
        onesided = mode_reg[MODE_BIT_ONESIDED];

        xe  = SW'(x_reg);
        f0e = SW'(f0_reg);
        f1e = SW'(f1_reg);
        w0e = SW'(w0_reg);
        w1e = SW'(w1_reg);
        w2e = SW'(w2_reg);

        // One-sided index 0
        if (second)
            s_zero = (f0e <<< 1) - (f1e + (f1e <<< 2)) + (w0e <<< 2) - xe;
        else
            s_zero = (f1e <<< 2) - (f0e + (f0e <<< 1)) - xe;

        // Interior index k-1
        if (second)
            s_inner = xe - (w0e <<< 1) + w1e;
        else
            s_inner = xe - w1e;

        // Index n
        if (onesided)
        begin
            if (second)
                s_end = (xe <<< 1) - (w0e + (w0e <<< 2)) + (w1e <<< 2) - w2e;
            else
                s_end = (xe + (xe <<< 1)) - (w0e <<< 2) + w1e;
        end
        else
        begin
            if (second)
                s_end = f0e - (xe <<< 1) + w0e;
            else
                s_end = f0e - w0e;
        end

        // Periodic index 0
        if (second)
            s_wrap = f1e - (f0e <<< 1) + xe;
        else
            s_wrap = f1e - xe;

        v_zero  = onesided && ((!second && k == IDX_W'(2)) || (second && k == IDX_W'(3)));
        v_inner = k >= IDX_W'(2);
        v_end   = k == n_eff;
        v_wrap  = v_end && !onesided;

        r_zero  = make_res(s_zero,  '0);
        r_inner = make_res(s_inner, k - IDX_W'(1));
        r_end   = make_res(s_end,   n_eff);
        r_wrap  = make_res(s_wrap,  '0);

        // Pack the valid results in order; the interior one is present whenever any is
        q_new.cnt    = 2'(v_zero) + 2'(v_inner) + 2'(v_end) + 2'(v_wrap);
        q_new.res[0] = v_zero ? r_zero  : r_inner;
        q_new.res[1] = v_zero ? r_inner : r_end;
        q_new.res[2] = v_zero ? r_end   : r_wrap;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (in_valid_reg)
        begin
            count_reg <= v_end ? '0 : k + IDX_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid_reg)
        begin
            if (k == IDX_W'(0))
                f0_reg <= x_reg;
            if (k == IDX_W'(1))
                f1_reg <= x_reg;
            w2_reg <= w1_reg;
            w1_reg <= w0_reg;
            w0_reg <= x_reg;
        end
    end

    // ------------------------------------------------------------------------
    // Item queue: one entry per sample that causes results
    // ------------------------------------------------------------------------
    qent_t             q_mem [Q_DEPTH];
    logic [QP_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [1:0]        slot_reg;
    logic              q_push, q_take, q_pop, slot_last;
    qent_t             q_head;
    res_t              q_sel;
    logic              prod_ready;

    assign q_push    = in_valid_reg && (q_new.cnt != 2'd0);
    assign q_head    = q_mem[rd_ptr_reg];
    assign slot_last = slot_reg == (q_head.cnt - 2'd1);
    assign q_take    = (q_count_reg != '0) && prod_ready;
    assign q_pop     = q_take && slot_last;

    always_comb
    begin
        case (slot_reg)
            2'd0:    q_sel = q_head.res[0];
            2'd1:    q_sel = q_head.res[1];
            2'd2:    q_sel = q_head.res[2];
            default: q_sel = q_head.res[0];
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (q_push)
        begin
            q_mem[wr_ptr_reg] <= q_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg  <= '0;
            rd_ptr_reg  <= '0;
            q_count_reg <= '0;
            slot_reg    <= '0;
        end
        else
        begin
            if (q_push)
                wr_ptr_reg <= wr_ptr_reg + QP_W'(1);
            if (q_pop)
                rd_ptr_reg <= rd_ptr_reg + QP_W'(1);
            q_count_reg <= q_count_reg + QC_W'(q_push) - QC_W'(q_pop);
            // Advance through the results of the head item, one per cycle while prod_ready is high
            if (q_take)
                slot_reg <= slot_last ? 2'd0 : slot_reg + 2'd1;
        end
    end

    // ------------------------------------------------------------------------
    // Scale product stage: |S| * scale split into low and high partials
    // ------------------------------------------------------------------------
    logic                 prod_valid_reg;
    logic [63:0]          lo_prod_reg;
    logic [HP_W-1:0]      hi_prod_reg;
    logic                 prod_neg_reg, prod_last_reg;
    logic [IDX_W-1:0]     prod_idx_reg;
    logic [MAG_PAD-1:0]   m_pad;
    logic                 out_ready;

    assign prod_ready = !prod_valid_reg || out_ready;
    assign m_pad      = MAG_PAD'(q_sel.mag);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
        end
        else if (prod_ready)
        begin
            prod_valid_reg <= q_take;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_take)
        begin
            lo_prod_reg   <= 64'(m_pad[31:0]) * 64'(scale_reg);
            hi_prod_reg   <= HP_W'(m_pad[MAG_PAD-1:32]) * HP_W'(scale_reg);
            prod_neg_reg  <= q_sel.neg;
            prod_idx_reg  <= q_sel.idx;
            prod_last_reg <= slot_last;
        end
    end

    // ------------------------------------------------------------------------
    // Round to nearest (ties away from zero), apply sign, saturate
    // ------------------------------------------------------------------------
    logic              big;
    logic [RND_W-1:0]  mag_rnd;
    logic              sat;
    logic [31:0]       val;

    always_comb
    begin
        big     = |hi_prod_reg[HP_W-1:16];
        mag_rnd = RND_W'({hi_prod_reg[15:0], 16'b0}) + RND_W'(lo_prod_reg[63:16])
                + RND_W'(lo_prod_reg[15]);
        if (prod_neg_reg)
        begin
            sat = big || (mag_rnd > RND_W'(NEG_LIMIT));
            val = sat ? NEG_LIMIT : (32'd0 - mag_rnd[31:0]);
        end
        else
        begin
            sat = big || (mag_rnd > RND_W'(POS_LIMIT));
            val = sat ? POS_LIMIT : mag_rnd[31:0];
        end
    end

    // ------------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------------
    logic               out_valid_reg;
    logic signed [31:0] deriv_reg;
    logic [IDX_W-1:0]   index_reg;
    logic               last_reg, sat_reg;

    // Hold the result while the consumer stalls
    assign out_ready = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_ready)
        begin
            out_valid_reg <= prod_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_ready && prod_valid_reg)
        begin
            deriv_reg <= val;
            index_reg <= prod_idx_reg;
            last_reg  <= prod_last_reg;
            sat_reg   <= sat;
        end
    end

    assign out_valid   = out_valid_reg;
    assign deriv_value = deriv_reg;
    assign point_index = index_reg;
    assign last_of_run = last_reg;
    assign saturated   = sat_reg;

endmodule

`default_nettype wire

### rtl/ufd_checker.sv
// ============================================================================
// ufd_checker - port-level checks for the derivative stream
// Watches the result channel of the top level; attached by bind.
// ============================================================================
`default_nettype none

module ufd_checker
    import ufd_pkg::*;
(
    input wire logic                           clk,
    input wire logic                           rst_n,
    input wire logic                           out_valid,
    input wire logic                           out_stall,
    input wire logic signed [31:0]             deriv_value,
    input wire logic [IDX_W-1:0]               point_index,
    input wire logic                           last_of_run,
    input wire logic                           saturated
);

    // Hold a stalled result transaction unchanged
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(deriv_value)
            && $stable(point_index) && $stable(last_of_run) && $stable(saturated))
        else $error("stalled result transaction changed");

    // The rest of a sample's results follow without a gap
    a_run_gapless: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last_of_run |=> out_valid)
        else $error("gap inside a run of results");

    // A clipped value sits exactly on a bound
    a_sat_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && saturated |->
            deriv_value == POS_LIMIT || deriv_value == NEG_LIMIT)
        else $error("saturated result not at a bound");

    // A non-final index 0 of a run is never the periodic wrap, so an interior
    // index follows it
    a_zero_then_more: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last_of_run && point_index == '0
            |=> point_index != '0)
        else $error("index 0 repeated within a run");

endmodule

bind uniform_fd_derivative_stream ufd_checker u_ufd_checker (.*);

`default_nettype wire
